FILE: sv/lskt_pkg.sv
// package: types, sizes and codes for the lazy sorted key table
`timescale 1ns / 1ps
package lskt_pkg;
    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_IDX = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [7:0]  position;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] result_index;
        logic       found;
        logic [8:0] entries_held;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RM_RD,
        S_RM_WR,
        S_SO_NEXT,
        S_SO_RDV,
        S_SO_RDJ,
        S_SO_CMP,
        S_BS_CHK,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } state_t;
endpackage

FILE: sv/lazy_sorted_key_table_core.sv
// top level: key table with append, remove, lazy insertion sort and binary search
//
// drive cmd and pulse start while busy is low; a transaction is taken at that edge
// and busy rises the next cycle. exactly one result appears on rsp with done
// high for one cycle; the receiver cannot stall it, so it must take it then.
// every transaction works through the single key memory:
//   insert / unused mode / error : straight to the result
//   remove at index p            : each key above p is read, then moved one place down
//   search, sorted               : each probe checks the bounds, reads the middle key
//     and compares it, until a match or an empty range
//   search, unsorted             : first an insertion sort; each key is read, each
//     compare reads the key below the hole and shifts it up or fills the hole, a key
//     reaching the front is written there, and a final check marks the table sorted
// a new transaction is taken the cycle after done.
// reset empties the table and marks it sorted; key contents are left as they
// were and only entries below the count are ever used.
`timescale 1ns / 1ps
module lazy_sorted_key_table_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lskt_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output lskt_pkg::rsp_t rsp
);
    import lskt_pkg::*;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic sorted_reg, sorted_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] v_reg, v_next;
    // sort: i outer, j hole; remove: i walks; search: lo, hi signed-ish bounds
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] ridx_reg, ridx_next;
    logic found_reg, found_next;

    logic rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [CNT_W:0] mid_w;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        v_reg      <= v_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        status_reg <= status_next;
        ridx_reg   <= ridx_next;
        found_reg  <= found_next;
    end

    assign mid_w = lo_reg + ((hi_reg - lo_reg) >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode_t'(cmd.mode))
                        MODE_INSERT: state_next = S_DONE;
                        MODE_REMOVE:
                            if ({1'b0, cmd.position} >= count_reg)
                                state_next = S_DONE;
                            else
                                state_next = S_RM_RD;
                        MODE_SEARCH: state_next = sorted_reg ? S_BS_CHK : S_SO_NEXT;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RM_RD:
                state_next = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2) > (CNT_W+1)'(count_reg))
                             ? S_DONE : S_RM_WR;
            S_RM_WR:   state_next = S_RM_RD;
            S_SO_NEXT: state_next = (i_reg >= count_reg) ? S_BS_CHK : S_SO_RDV;
            S_SO_RDV:  state_next = S_SO_RDJ;
            S_SO_RDJ:  state_next = (j_reg == '0) ? S_SO_NEXT : S_SO_CMP;
            S_SO_CMP:  state_next = (rd_data_reg > v_reg) ? S_SO_RDJ : S_SO_NEXT;
            S_BS_CHK:
                state_next = (count_reg == '0 || $signed(lo_reg) > $signed(hi_reg))
                             ? S_DONE : S_BS_RD;
            S_BS_RD:   state_next = S_BS_CMP;
            S_BS_CMP:  state_next = (rd_data_reg == key_reg) ? S_DONE : S_BS_CHK;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next  = count_reg;
        sorted_next = sorted_reg;
        key_next    = key_reg;
        v_next      = v_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        status_next = status_reg;
        ridx_next   = ridx_reg;
        found_next  = found_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = v_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next    = KEY_WIDTH'(cmd.key);
                    status_next = ST_OK;
                    ridx_next   = '0;
                    found_next  = 1'b0;
                    i_next      = CNT_W'(cmd.position);
                    lo_next     = '0;
                    hi_next     = (CNT_W+1)'(count_reg) - 1'b1;
                    mid_next    = '0;
                    unique case (mode_t'(cmd.mode))
                        MODE_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_data     = KEY_WIDTH'(cmd.key);
                                ridx_next   = 8'(count_reg);
                                count_next  = count_reg + 1'b1;
                                sorted_next = 1'b0;
                            end
                        end
                        MODE_REMOVE:
                            if ({1'b0, cmd.position} >= count_reg)
                                status_next = ST_BAD_IDX;
                        MODE_SEARCH: i_next = CNT_W'(1);
                        default: ;
                    endcase
                end
            end
            S_RM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(i_reg + 1'b1);
                if ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2) > (CNT_W+1)'(count_reg))
                    count_next = count_reg - 1'b1;
            end
            S_RM_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
                i_next  = i_reg + 1'b1;
            end
            S_SO_NEXT:
            begin
                if (i_reg >= count_reg)
                    sorted_next = 1'b1;
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = i_reg[IDX_W-1:0];
                    j_next  = i_reg;
                end
            end
            S_SO_RDV:
                v_next = rd_data_reg;
            S_SO_RDJ:
            begin
                if (j_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(j_reg - 1'b1);
                end
            end
            S_SO_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
                if (rd_data_reg > v_reg)
                begin
                    // shift larger key up and move the hole down
                    wr_data = rd_data_reg;
                    j_next  = j_reg - 1'b1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_BS_CHK:
            begin
                if (count_reg != '0 && $signed(lo_reg) <= $signed(hi_reg))
                begin
                    mid_next = CNT_W'(mid_w);
                    ridx_next = 8'(mid_w);
                end
            end
            S_BS_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = mid_reg[IDX_W-1:0];
            end
            S_BS_CMP:
            begin
                if (rd_data_reg == key_reg)
                    found_next = 1'b1;
                else if (rd_data_reg < key_reg)
                    lo_next = (CNT_W+1)'(mid_reg) + 1'b1;
                else
                    hi_next = (CNT_W+1)'(mid_reg) - 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        rsp.status       = status_reg;
        rsp.result_index = ridx_reg;
        rsp.found        = found_reg;
        rsp.entries_held = 9'(count_reg);
    end
endmodule
